// ===== hw/rtl/jsu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string unescaper package
// Shared types and constants for the JSON string to UTF-8 unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 24;
   localparam int CSR_WIDTH           = 24;
   localparam logic [CSR_WIDTH-1:0] CSR_RESET = 24'hFF_FFFF;

   // A single input beat can cause at most this many result beats.
   localparam int MAX_ITEMS      = 4;
   localparam int ITEM_IDX_WIDTH = $clog2(MAX_ITEMS);
   localparam int ITEM_N_WIDTH   = $clog2(MAX_ITEMS + 1);

   localparam int QUEUE_DEPTH    = 8;
   localparam int LEVEL_WIDTH    = $clog2(QUEUE_DEPTH + 1);

   localparam logic [3:0] ERR_NONE      = 4'd0;
   localparam logic [3:0] ERR_NO_QUOTE  = 4'd1;
   localparam logic [3:0] ERR_CONTROL   = 4'd2;
   localparam logic [3:0] ERR_TRUNC_ESC = 4'd3;
   localparam logic [3:0] ERR_BAD_HEX   = 4'd4;
   localparam logic [3:0] ERR_BAD_SURR  = 4'd5;
   localparam logic [3:0] ERR_BAD_ESC   = 4'd6;
   localparam logic [3:0] ERR_UNTERM    = 4'd7;
   localparam logic [3:0] ERR_TOO_LARGE = 4'd8;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_BODY,
      PH_ESC,
      PH_HEX,
      PH_PBS,
      PH_PU,
      PH_LHEX
   } phase_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       string_done;
      logic [3:0] error_code;
      logic       last_of_run;
   } rsp_type;

endpackage

// ===== hw/rtl/jsu_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string unescaper decode stage
// Holds the parse state and turns one input beat into up to four results.
// ----------------------------------------------------------------------------
module jsu_decode #(
   parameter int COUNT_WIDTH = jsu_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         accept,
   input  jsu_pkg::req_type                             req,
   input  logic [jsu_pkg::CSR_WIDTH-1:0]                limit,
   output jsu_pkg::rsp_type [jsu_pkg::MAX_ITEMS-1:0]    items,
   output logic [jsu_pkg::ITEM_N_WIDTH-1:0]             n_items
);

   localparam int SUM_WIDTH =
      ((COUNT_WIDTH > jsu_pkg::CSR_WIDTH) ? COUNT_WIDTH : jsu_pkg::CSR_WIDTH) + 1;

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_U      = 8'h75;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [5:0] SUR_HIGH  = 6'b110110;
   localparam logic [5:0] SUR_LOW   = 6'b110111;

   typedef struct packed {
      logic [2:0]       len;
      logic [3:0][7:0]  bytes;
   } utf8_type;

   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, c[3:0]};
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         r = {1'b1, c[3:0] + 4'd9};
      end
      return r;
   endfunction

   // Simple escape letters; the top bit says the letter is one of them.
   function automatic logic [8:0] esc_value(input logic [7:0] c);
      logic [8:0] r;
      unique case (c)
         CH_QUOTE, CH_BSLASH, CH_SLASH: r = {1'b1, c};
         8'h62:   r = {1'b1, 8'h08};
         8'h66:   r = {1'b1, 8'h0C};
         8'h6E:   r = {1'b1, 8'h0A};
         8'h72:   r = {1'b1, 8'h0D};
         8'h74:   r = {1'b1, 8'h09};
         default: r = 9'd0;
      endcase
      return r;
   endfunction

   function automatic utf8_type utf8_encode(input logic [20:0] cp);
      utf8_type r;
      r.bytes = '0;
      if (cp < 21'h80) begin
         r.len      = 3'd1;
         r.bytes[0] = cp[7:0];
      end else if (cp < 21'h800) begin
         r.len      = 3'd2;
         r.bytes[0] = {3'b110, cp[10:6]};
         r.bytes[1] = {2'b10, cp[5:0]};
      end else if (cp < 21'h10000) begin
         r.len      = 3'd3;
         r.bytes[0] = {4'b1110, cp[15:12]};
         r.bytes[1] = {2'b10, cp[11:6]};
         r.bytes[2] = {2'b10, cp[5:0]};
      end else begin
         r.len      = 3'd4;
         r.bytes[0] = {5'b11110, cp[20:18]};
         r.bytes[1] = {2'b10, cp[17:12]};
         r.bytes[2] = {2'b10, cp[11:6]};
         r.bytes[3] = {2'b10, cp[5:0]};
      end
      return r;
   endfunction

   jsu_pkg::phase_type     phase_ff, phase_in;
   logic [15:0]            hex_value_ff, hex_value_in;
   logic [1:0]             hex_cnt_ff, hex_cnt_in;
   logic [9:0]             high_sur_ff, high_sur_in;
   logic [COUNT_WIDTH-1:0] out_count_ff, out_count_in;
   logic                   overflow_ff, overflow_in;

   // Actions of one beat, always in this order: a code point, a single
   // byte, then a status beat.
   logic                   clear_count;
   logic                   a_en;
   logic [20:0]            a_cp;
   logic                   b_en;
   logic [7:0]             b_byte;
   logic                   s_en;
   logic                   s_close;
   logic [3:0]             s_err;

   logic [20:0]            flush_cp;
   assign flush_cp = {5'd0, SUR_HIGH, high_sur_ff};

   always_comb begin
      logic [4:0]  dig;
      logic [15:0] hv_new;
      logic [8:0]  ev;
      logic        do_body;
      logic        do_esc;
      logic        do_hex;
      logic        low;
      dig          = hex_digit(req.in_byte);
      hv_new       = {hex_value_ff[11:0], dig[3:0]};
      ev           = esc_value(req.in_byte);
      low          = (phase_ff == jsu_pkg::PH_LHEX);
      do_body      = 1'b0;
      do_esc       = 1'b0;
      do_hex       = 1'b0;
      phase_in     = phase_ff;
      hex_value_in = hex_value_ff;
      hex_cnt_in   = hex_cnt_ff;
      high_sur_in  = high_sur_ff;
      clear_count  = 1'b0;
      a_en         = 1'b0;
      a_cp         = '0;
      b_en         = 1'b0;
      b_byte       = '0;
      s_en         = 1'b0;
      s_close      = 1'b0;
      s_err        = jsu_pkg::ERR_NONE;
      if (req.end_of_input) begin
         s_en = 1'b1;
         unique case (phase_ff)
            jsu_pkg::PH_IDLE: s_err = jsu_pkg::ERR_NO_QUOTE;
            jsu_pkg::PH_BODY: s_err = jsu_pkg::ERR_UNTERM;
            jsu_pkg::PH_ESC:  s_err = jsu_pkg::ERR_TRUNC_ESC;
            jsu_pkg::PH_HEX:  s_err = jsu_pkg::ERR_BAD_HEX;
            jsu_pkg::PH_PBS: begin
               a_en  = 1'b1;
               a_cp  = flush_cp;
               s_err = jsu_pkg::ERR_UNTERM;
            end
            jsu_pkg::PH_PU: begin
               a_en  = 1'b1;
               a_cp  = flush_cp;
               s_err = jsu_pkg::ERR_TRUNC_ESC;
            end
            jsu_pkg::PH_LHEX: begin
               if (hex_cnt_ff == 2'd0) begin
                  a_en  = 1'b1;
                  a_cp  = flush_cp;
                  s_err = jsu_pkg::ERR_BAD_HEX;
               end else begin
                  s_err = jsu_pkg::ERR_BAD_SURR;
               end
            end
            default: s_err = jsu_pkg::ERR_NO_QUOTE;
         endcase
      end else begin
         unique case (phase_ff)
            jsu_pkg::PH_IDLE: begin
               if (req.in_byte == CH_QUOTE) begin
                  phase_in    = jsu_pkg::PH_BODY;
                  clear_count = 1'b1;
               end else begin
                  s_en  = 1'b1;
                  s_err = jsu_pkg::ERR_NO_QUOTE;
               end
            end
            jsu_pkg::PH_BODY: do_body = 1'b1;
            jsu_pkg::PH_ESC:  do_esc  = 1'b1;
            jsu_pkg::PH_HEX, jsu_pkg::PH_LHEX: do_hex = 1'b1;
            jsu_pkg::PH_PBS: begin
               if (req.in_byte == CH_BSLASH) begin
                  phase_in = jsu_pkg::PH_PU;
               end else begin
                  // Lone high surrogate: flush it, then treat the byte as text.
                  a_en     = 1'b1;
                  a_cp     = flush_cp;
                  phase_in = jsu_pkg::PH_BODY;
                  do_body  = 1'b1;
               end
            end
            jsu_pkg::PH_PU: begin
               if (req.in_byte == CH_U) begin
                  phase_in     = jsu_pkg::PH_LHEX;
                  hex_value_in = '0;
                  hex_cnt_in   = '0;
               end else begin
                  a_en   = 1'b1;
                  a_cp   = flush_cp;
                  do_esc = 1'b1;
               end
            end
            default: begin
               s_en  = 1'b1;
               s_err = jsu_pkg::ERR_NO_QUOTE;
            end
         endcase
      end

      if (do_body) begin
         priority if (req.in_byte == CH_QUOTE) begin
            s_en    = 1'b1;
            s_close = 1'b1;
         end else if (req.in_byte < CH_SPACE) begin
            s_en  = 1'b1;
            s_err = jsu_pkg::ERR_CONTROL;
         end else if (req.in_byte == CH_BSLASH) begin
            phase_in = jsu_pkg::PH_ESC;
         end else begin
            b_en   = 1'b1;
            b_byte = req.in_byte;
         end
      end

      if (do_esc) begin
         priority if (ev[8]) begin
            b_en     = 1'b1;
            b_byte   = ev[7:0];
            phase_in = jsu_pkg::PH_BODY;
         end else if (req.in_byte == CH_U) begin
            phase_in     = jsu_pkg::PH_HEX;
            hex_value_in = '0;
            hex_cnt_in   = '0;
         end else begin
            s_en  = 1'b1;
            s_err = jsu_pkg::ERR_BAD_ESC;
         end
      end

      if (do_hex) begin
         if (!dig[4]) begin
            s_en  = 1'b1;
            s_err = low ? jsu_pkg::ERR_BAD_SURR : jsu_pkg::ERR_BAD_HEX;
         end else begin
            hex_value_in = hv_new;
            // The two-bit digit count wraps to zero on the fourth digit.
            hex_cnt_in   = hex_cnt_ff + 2'd1;
            if (hex_cnt_ff == 2'd3) begin
               if (low) begin
                  if (hv_new[15:10] != SUR_LOW) begin
                     s_en  = 1'b1;
                     s_err = jsu_pkg::ERR_BAD_SURR;
                  end else begin
                     phase_in = jsu_pkg::PH_BODY;
                     a_en     = 1'b1;
                     a_cp     = 21'h10000 + {1'b0, high_sur_ff, hv_new[9:0]};
                  end
               end else if (hv_new[15:10] == SUR_HIGH) begin
                  high_sur_in = hv_new[9:0];
                  phase_in    = jsu_pkg::PH_PBS;
               end else begin
                  phase_in = jsu_pkg::PH_BODY;
                  a_en     = 1'b1;
                  a_cp     = {5'd0, hv_new};
               end
            end
         end
      end

      if (s_en) begin
         phase_in = jsu_pkg::PH_IDLE;
      end
   end

   // Length check and result assembly. A sequence that does not fit whole
   // is dropped and marks the string as too large.
   always_comb begin
      utf8_type                             enc;
      logic [SUM_WIDTH-1:0]                 cap;
      logic [SUM_WIDTH-1:0]                 lim;
      logic [COUNT_WIDTH-1:0]               cnt0;
      logic [COUNT_WIDTH-1:0]               cnt1;
      logic                                 ovf0;
      logic                                 ovf1;
      logic                                 a_ok;
      logic                                 b_ok;
      logic [2:0]                           na;
      logic [2:0]                           pos_s;
      logic [jsu_pkg::ITEM_N_WIDTH-1:0]     total;
      enc   = utf8_encode(a_cp);
      cap   = SUM_WIDTH'({COUNT_WIDTH{1'b1}});
      lim   = (SUM_WIDTH'(limit) > cap) ? cap : SUM_WIDTH'(limit);
      cnt0  = clear_count ? '0 : out_count_ff;
      ovf0  = clear_count ? 1'b0 : overflow_ff;
      a_ok  = a_en && !ovf0 &&
              (SUM_WIDTH'(cnt0) + SUM_WIDTH'(enc.len) <= lim);
      ovf1  = ovf0 | (a_en & ~a_ok);
      cnt1  = a_ok ? cnt0 + COUNT_WIDTH'(enc.len) : cnt0;
      b_ok  = b_en && !ovf1 && (SUM_WIDTH'(cnt1) + SUM_WIDTH'(1) <= lim);
      overflow_in  = ovf1 | (b_en & ~b_ok);
      out_count_in = b_ok ? cnt1 + COUNT_WIDTH'(1) : cnt1;
      na    = a_ok ? enc.len : 3'd0;
      pos_s = na + {2'd0, b_ok};
      total = jsu_pkg::ITEM_N_WIDTH'(pos_s + {2'd0, s_en});
      n_items = total;
      for (int k = 0; k < jsu_pkg::MAX_ITEMS; k++) begin
         items[k] = '0;
         if (3'(k) < na) begin
            items[k].out_byte   = enc.bytes[k];
            items[k].byte_valid = 1'b1;
         end else if (b_ok && 3'(k) == na) begin
            items[k].out_byte   = b_byte;
            items[k].byte_valid = 1'b1;
         end else if (s_en && 3'(k) == pos_s) begin
            if (s_close) begin
               items[k].string_done = ~ovf1;
               items[k].error_code  = ovf1 ? jsu_pkg::ERR_TOO_LARGE : jsu_pkg::ERR_NONE;
            end else begin
               items[k].error_code  = s_err;
            end
         end
         items[k].last_of_run = (3'(k) + 3'd1 == 3'(total));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= jsu_pkg::PH_IDLE;
         hex_value_ff <= '0;
         hex_cnt_ff   <= '0;
         high_sur_ff  <= '0;
         out_count_ff <= '0;
         overflow_ff  <= 1'b0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         hex_value_ff <= hex_value_in;
         hex_cnt_ff   <= hex_cnt_in;
         high_sur_ff  <= high_sur_in;
         out_count_ff <= out_count_in;
         overflow_ff  <= overflow_in;
      end
   end

endmodule

// ===== hw/rtl/jsu_outq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string unescaper result queue
// Shift queue taking up to four results at once, one out per cycle on ready.
// ----------------------------------------------------------------------------
module jsu_outq (
   input  logic                                         clock,
   input  logic                                         reset,
   input  jsu_pkg::rsp_type [jsu_pkg::MAX_ITEMS-1:0]    push_items,
   input  logic [jsu_pkg::ITEM_N_WIDTH-1:0]             push_n,
   input  logic                                         rsp_ready,
   output logic                                         rsp_valid,
   output jsu_pkg::rsp_type                             rsp_data,
   output logic                                         room,
   output logic [jsu_pkg::LEVEL_WIDTH-1:0]              level
);

   localparam int LW = jsu_pkg::LEVEL_WIDTH;

   jsu_pkg::rsp_type q_ff    [jsu_pkg::QUEUE_DEPTH];
   jsu_pkg::rsp_type q_in    [jsu_pkg::QUEUE_DEPTH];
   jsu_pkg::rsp_type shifted [jsu_pkg::QUEUE_DEPTH];
   logic [LW-1:0]    level_ff, level_in;
   logic             pop;

   assign rsp_valid = (level_ff != '0);
   assign rsp_data  = q_ff[0];
   assign pop       = rsp_valid & rsp_ready;
   assign room      = (level_ff <= LW'(jsu_pkg::QUEUE_DEPTH - jsu_pkg::MAX_ITEMS));
   assign level     = level_ff;

   always_comb begin
      for (int i = 0; i < jsu_pkg::QUEUE_DEPTH - 1; i++) begin
         shifted[i] = q_ff[i + 1];
      end
      shifted[jsu_pkg::QUEUE_DEPTH - 1] = q_ff[jsu_pkg::QUEUE_DEPTH - 1];
   end

   // Entries below the surviving level move down on a pop; new beats are
   // appended right after them.
   always_comb begin
      logic [LW-1:0] base;
      logic [LW-1:0] k;
      base = level_ff - LW'(pop);
      for (int i = 0; i < jsu_pkg::QUEUE_DEPTH; i++) begin
         k = LW'(i) - base;
         if (LW'(i) < base) begin
            q_in[i] = pop ? shifted[i] : q_ff[i];
         end else if (k < LW'(push_n)) begin
            q_in[i] = push_items[k[jsu_pkg::ITEM_IDX_WIDTH-1:0]];
         end else begin
            q_in[i] = q_ff[i];
         end
      end
      level_in = base + LW'(push_n);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
      end else begin
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < jsu_pkg::QUEUE_DEPTH; i++) begin
         q_ff[i] <= q_in[i];
      end
   end

endmodule

// ===== hw/rtl/json_string_unescape_utf8_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string unescaper, top level
// Decodes a JSON string literal, one text byte per beat, into UTF-8 bytes
// with done and error status beats.
//
//   Channel  Ports                           Direction  Payload
//   req      req_valid/req_ready/req_data    in         in_byte, end_of_input
//   rsp      rsp_valid/rsp_ready/rsp_data    out        byte, status, last flag
//   csr      csr_wr_en/csr_wr_data           in         max_output_len (24 b)
//
// One request beat is taken per cycle while the queue has room; its results
// (up to four) reach an eight-entry result queue at the next edge and leave
// one per cycle while rsp_ready is high. The request side is ready while the
// queue holds four or fewer beats, so a run of plain bytes flows at one beat
// per cycle; multi-byte sequences stall the input only when the queue fills.
// Reset is synchronous and returns the parser to idle, empties the queue and
// sets the length limit to its largest value.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_top #(
   parameter int COUNT_WIDTH = jsu_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  jsu_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output jsu_pkg::rsp_type              rsp_data,
   input  logic                          csr_wr_en,
   input  logic [jsu_pkg::CSR_WIDTH-1:0] csr_wr_data
);

   logic [jsu_pkg::CSR_WIDTH-1:0]             max_output_len_ff;
   jsu_pkg::rsp_type [jsu_pkg::MAX_ITEMS-1:0] items;
   logic [jsu_pkg::ITEM_N_WIDTH-1:0]          n_items;
   logic [jsu_pkg::ITEM_N_WIDTH-1:0]          push_n;
   logic [jsu_pkg::LEVEL_WIDTH-1:0]           level;
   logic                                      accept;

   assign accept = req_valid & req_ready;
   assign push_n = accept ? n_items : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_output_len_ff <= jsu_pkg::CSR_RESET;
      end else if (csr_wr_en) begin
         max_output_len_ff <= csr_wr_data;
      end
   end

   jsu_decode #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_decode (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .req     (req_data),
      .limit   (max_output_len_ff),
      .items   (items),
      .n_items (n_items)
   );

   jsu_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .push_items (items),
      .push_n     (push_n),
      .rsp_ready  (rsp_ready),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .room       (req_ready),
      .level      (level)
   );

   // The queue never holds more beats than it has entries.
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level <= jsu_pkg::LEVEL_WIDTH'(jsu_pkg::QUEUE_DEPTH))
      else $error("result queue level exceeds its depth");

   // A status beat always closes the run of results from its request beat.
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.byte_valid |-> rsp_data.last_of_run)
      else $error("status beat not marked last of run");

   // A clean close carries no error and no byte.
   a_done_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.string_done |->
         rsp_data.error_code == jsu_pkg::ERR_NONE && !rsp_data.byte_valid)
      else $error("done beat with error or data");

   // Byte beats never carry status.
   a_byte_plain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.byte_valid |->
         rsp_data.error_code == jsu_pkg::ERR_NONE && !rsp_data.string_done)
      else $error("byte beat with status set");

endmodule

// ===== tb/json_string_unescape_utf8_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string unescaper, scoreboard
// Watches the request, result and register ports of the unescaper, works out
// the decoded bytes and status beats that each accepted request beat should
// cause, and compares every accepted result beat with the oldest one due.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_checker #(
   parameter int COUNT_WIDTH = jsu_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  jsu_pkg::req_type              req_data,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  jsu_pkg::rsp_type              rsp_data,
   input  logic                          csr_wr_en,
   input  logic [jsu_pkg::CSR_WIDTH-1:0] csr_wr_data,
   output int                            fail_count,
   output int                            pending
);

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_U      = 8'h75;

   logic [jsu_pkg::CSR_WIDTH-1:0] len_limit;
   jsu_pkg::phase_type            parse_phase;
   logic [15:0]                   hex_acc;
   logic [2:0]                    hex_cnt;
   logic [15:0]                   high_half;
   logic [23:0]                   byte_count;
   logic                          overflowed;

   jsu_pkg::rsp_type decoded_q[$];
   jsu_pkg::rsp_type beat_items[$];

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   task automatic emit_item(input logic [7:0] b, input logic v, input logic d,
                            input logic [3:0] e);
      jsu_pkg::rsp_type it;
      if (beat_items.size() < jsu_pkg::MAX_ITEMS) begin
         it.out_byte    = b;
         it.byte_valid  = v;
         it.string_done = d;
         it.error_code  = e;
         it.last_of_run = 1'b0;
         beat_items.push_back(it);
      end
   endtask

   task automatic close_string(input logic d, input logic [3:0] e);
      emit_item(8'h00, 1'b0, d, e);
      parse_phase = jsu_pkg::PH_IDLE;
   endtask

   function automatic longint unsigned limit_in_force();
      longint unsigned cap;
      longint unsigned lim;
      cap = (longint'(1) << COUNT_WIDTH) - 1;
      lim = len_limit;
      return (lim < cap) ? lim : cap;
   endfunction

   // A sequence that does not fit whole is dropped, and so is all that follows.
   task automatic put_seq(input logic [3:0][7:0] seq, input int n);
      if (overflowed || longint'(byte_count) + n > limit_in_force()) begin
         overflowed = 1'b1;
      end else begin
         for (int k = 0; k < n; k++) emit_item(seq[k], 1'b1, 1'b0, jsu_pkg::ERR_NONE);
         byte_count = byte_count + 24'(n);
      end
   endtask

   task automatic put_code_point(input logic [20:0] cp);
      logic [3:0][7:0] s;
      int              n;
      s = '0;
      if (cp < 21'h80) begin
         s[0] = cp[7:0];
         n = 1;
      end else if (cp < 21'h800) begin
         s[0] = {3'b110, cp[10:6]};
         s[1] = {2'b10, cp[5:0]};
         n = 2;
      end else if (cp < 21'h10000) begin
         s[0] = {4'b1110, cp[15:12]};
         s[1] = {2'b10, cp[11:6]};
         s[2] = {2'b10, cp[5:0]};
         n = 3;
      end else begin
         s[0] = {5'b11110, cp[20:18]};
         s[1] = {2'b10, cp[17:12]};
         s[2] = {2'b10, cp[11:6]};
         s[3] = {2'b10, cp[5:0]};
         n = 4;
      end
      put_seq(s, n);
   endtask

   function automatic int nibble_of(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "A" && c <= "F") return int'(c - "A") + 10;
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      return -1;
   endfunction

   task automatic body_char(input logic [7:0] c);
      logic [3:0][7:0] s;
      if (c == CH_QUOTE) begin
         if (overflowed) close_string(1'b0, jsu_pkg::ERR_TOO_LARGE);
         else close_string(1'b1, jsu_pkg::ERR_NONE);
      end else if (c < 8'h20) begin
         close_string(1'b0, jsu_pkg::ERR_CONTROL);
      end else if (c == CH_BSLASH) begin
         parse_phase = jsu_pkg::PH_ESC;
      end else begin
         s = '0;
         s[0] = c;
         put_seq(s, 1);
      end
   endtask

   task automatic escape_char(input logic [7:0] e);
      logic [3:0][7:0] s;
      logic            plain;
      s = '0;
      plain = 1'b1;
      case (e)
         CH_QUOTE, CH_BSLASH, CH_SLASH: s[0] = e;
         "b": s[0] = 8'h08;
         "f": s[0] = 8'h0C;
         "n": s[0] = 8'h0A;
         "r": s[0] = 8'h0D;
         "t": s[0] = 8'h09;
         CH_U: begin
            parse_phase = jsu_pkg::PH_HEX;
            hex_acc = '0;
            hex_cnt = '0;
            plain = 1'b0;
         end
         default: begin
            close_string(1'b0, jsu_pkg::ERR_BAD_ESC);
            plain = 1'b0;
         end
      endcase
      if (plain) begin
         parse_phase = jsu_pkg::PH_BODY;
         put_seq(s, 1);
      end
   endtask

   task automatic hex_char(input logic [7:0] c, input logic low);
      int          d;
      int unsigned cp;
      d = nibble_of(c);
      if (d < 0) begin
         close_string(1'b0, low ? jsu_pkg::ERR_BAD_SURR : jsu_pkg::ERR_BAD_HEX);
         return;
      end
      hex_acc = {hex_acc[11:0], d[3:0]};
      hex_cnt = hex_cnt + 3'd1;
      if (hex_cnt < 3'd4) return;
      hex_cnt = '0;
      if (low) begin
         if (hex_acc < 16'hDC00 || hex_acc > 16'hDFFF) begin
            close_string(1'b0, jsu_pkg::ERR_BAD_SURR);
            return;
         end
         parse_phase = jsu_pkg::PH_BODY;
         cp = 32'h10000 + ((32'(high_half) - 32'hD800) << 10) + (32'(hex_acc) - 32'hDC00);
         put_code_point(cp[20:0]);
      end else if (hex_acc >= 16'hD800 && hex_acc <= 16'hDBFF) begin
         high_half = hex_acc;
         parse_phase = jsu_pkg::PH_PBS;
      end else begin
         parse_phase = jsu_pkg::PH_BODY;
         put_code_point({5'd0, hex_acc});
      end
   endtask

   task automatic decode_beat(input jsu_pkg::req_type r);
      jsu_pkg::rsp_type tail;
      beat_items.delete();
      if (r.end_of_input) begin
         case (parse_phase)
            jsu_pkg::PH_BODY: close_string(1'b0, jsu_pkg::ERR_UNTERM);
            jsu_pkg::PH_ESC:  close_string(1'b0, jsu_pkg::ERR_TRUNC_ESC);
            jsu_pkg::PH_HEX:  close_string(1'b0, jsu_pkg::ERR_BAD_HEX);
            jsu_pkg::PH_PBS: begin
               put_code_point({5'd0, high_half});
               close_string(1'b0, jsu_pkg::ERR_UNTERM);
            end
            jsu_pkg::PH_PU: begin
               put_code_point({5'd0, high_half});
               close_string(1'b0, jsu_pkg::ERR_TRUNC_ESC);
            end
            jsu_pkg::PH_LHEX: begin
               if (hex_cnt == 3'd0) begin
                  put_code_point({5'd0, high_half});
                  close_string(1'b0, jsu_pkg::ERR_BAD_HEX);
               end else begin
                  close_string(1'b0, jsu_pkg::ERR_BAD_SURR);
               end
            end
            default: close_string(1'b0, jsu_pkg::ERR_NO_QUOTE);
         endcase
      end else begin
         case (parse_phase)
            jsu_pkg::PH_IDLE: begin
               if (r.in_byte == CH_QUOTE) begin
                  parse_phase = jsu_pkg::PH_BODY;
                  byte_count = '0;
                  overflowed = 1'b0;
               end else begin
                  close_string(1'b0, jsu_pkg::ERR_NO_QUOTE);
               end
            end
            jsu_pkg::PH_BODY: body_char(r.in_byte);
            jsu_pkg::PH_ESC:  escape_char(r.in_byte);
            jsu_pkg::PH_HEX:  hex_char(r.in_byte, 1'b0);
            jsu_pkg::PH_PBS: begin
               if (r.in_byte == CH_BSLASH) begin
                  parse_phase = jsu_pkg::PH_PU;
               end else begin
                  put_code_point({5'd0, high_half});
                  parse_phase = jsu_pkg::PH_BODY;
                  body_char(r.in_byte);
               end
            end
            jsu_pkg::PH_PU: begin
               if (r.in_byte == CH_U) begin
                  parse_phase = jsu_pkg::PH_LHEX;
                  hex_acc = '0;
                  hex_cnt = '0;
               end else begin
                  put_code_point({5'd0, high_half});
                  escape_char(r.in_byte);
               end
            end
            jsu_pkg::PH_LHEX: hex_char(r.in_byte, 1'b1);
            default: close_string(1'b0, jsu_pkg::ERR_NO_QUOTE);
         endcase
      end
      if (beat_items.size() > 0) begin
         tail = beat_items.pop_back();
         tail.last_of_run = 1'b1;
         beat_items.push_back(tail);
      end
      foreach (beat_items[k]) decoded_q.push_back(beat_items[k]);
   endtask

   always @(posedge clock) begin
      jsu_pkg::rsp_type want;
      if (reset) begin
         len_limit   = jsu_pkg::CSR_RESET;
         parse_phase = jsu_pkg::PH_IDLE;
         hex_acc     = '0;
         hex_cnt     = '0;
         high_half   = '0;
         byte_count  = '0;
         overflowed  = 1'b0;
         decoded_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (decoded_q.size() == 0) begin
               if (fail_count < 10)
                  $display({"%0t: result beat with nothing due: ",
                            "byte %02h valid %0b done %0b err %0d last %0b"},
                           $realtime, rsp_data.out_byte, rsp_data.byte_valid,
                           rsp_data.string_done, rsp_data.error_code,
                           rsp_data.last_of_run);
               fail_count++;
            end else begin
               want = decoded_q.pop_front();
               if (rsp_data.out_byte !== want.out_byte ||
                   rsp_data.byte_valid !== want.byte_valid ||
                   rsp_data.string_done !== want.string_done ||
                   rsp_data.error_code !== want.error_code ||
                   rsp_data.last_of_run !== want.last_of_run) begin
                  if (fail_count < 10) begin
                     $display({"%0t: mismatch, expected byte %02h valid %0b ",
                               "done %0b err %0d last %0b"},
                              $realtime, want.out_byte, want.byte_valid,
                              want.string_done, want.error_code, want.last_of_run);
                     $display({"%0t:           actual   byte %02h valid %0b ",
                               "done %0b err %0d last %0b"},
                              $realtime, rsp_data.out_byte, rsp_data.byte_valid,
                              rsp_data.string_done, rsp_data.error_code,
                              rsp_data.last_of_run);
                  end
                  fail_count++;
               end
            end
         end
         if (csr_wr_en) len_limit = csr_wr_data;
         if (req_valid && req_ready) decode_beat(req_data);
      end
      pending = decoded_q.size();
   end

endmodule

// ===== tb/tb_json_string_unescape_utf8_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string unescaper testbench
// Drives directed JSON string literals covering every escape, surrogate case
// and error, then random strings, well formed and damaged, under several
// length limits and handshake idling patterns. The scoreboard beside the
// block checks every result beat; this module only drives and gives the
// verdict.
// ----------------------------------------------------------------------------
module tb_json_string_unescape_utf8_top;

   localparam int CYCLE_LIMIT  = 300000;
   localparam int HOLD_CYCLES  = 300;
   localparam int PHASE_BEATS  = 6;
   localparam int SETTLE       = 12;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;

   logic                          clock;
   logic                          reset       = 1'b1;
   logic                          req_valid   = 1'b0;
   logic                          req_ready;
   jsu_pkg::req_type              req_data    = '0;
   logic                          rsp_valid;
   logic                          rsp_ready   = 1'b0;
   jsu_pkg::rsp_type              rsp_data;
   logic                          csr_wr_en   = 1'b0;
   logic [jsu_pkg::CSR_WIDTH-1:0] csr_wr_data = '0;

   int fail_count;
   int pending;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_req      = 0;
   int hold_seen     = 0;
   int hold_left     = 0;
   int beats_sent    = 0;
   int cycles        = 0;

   logic [7:0] text_q[$];

   json_string_unescape_utf8_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   json_string_unescape_utf8_checker scoreboard (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("tb_json_string_unescape_utf8_top NOT OK");
      $finish;
   end

   // Result side: random stalls, and a long hold-off whenever one is requested.
   always @(negedge clock) begin
      if (hold_req != hold_seen) begin
         hold_seen = hold_req;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_beat(input logic [7:0] b, input logic e);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{in_byte: b, end_of_input: e};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      beats_sent++;
   endtask

   task automatic send_text(input string s);
      for (int k = 0; k < s.len(); k++) send_beat(s[k], 1'b0);
   endtask

   task automatic send_eoi();
      send_beat(8'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_limit(input logic [jsu_pkg::CSR_WIDTH-1:0] v);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [7:0] hex_ascii(input logic [3:0] n);
      if (n < 4'd10) return "0" + n;
      if ($urandom_range(0, 1)) return "A" + (n - 4'd10);
      return "a" + (n - 4'd10);
   endfunction

   task automatic add_u(input logic [15:0] v);
      text_q.push_back(CH_BSLASH);
      text_q.push_back("u");
      for (int k = 3; k >= 0; k--) text_q.push_back(hex_ascii(v[4*k +: 4]));
   endtask

   task automatic build_string();
      string      esc_letters;
      logic [7:0] c;
      logic [15:0] v;
      int         pieces;
      esc_letters = "\"\\/bfnrt";
      text_q.delete();
      text_q.push_back(CH_QUOTE);
      pieces = $urandom_range(0, 5);
      repeat (pieces) begin
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               c = 8'($urandom_range(32, 126));
               if (c == CH_QUOTE || c == CH_BSLASH) c = "a";
               text_q.push_back(c);
            end
            3: text_q.push_back(8'($urandom_range(127, 255)));
            4: begin
               text_q.push_back(CH_BSLASH);
               text_q.push_back(esc_letters[$urandom_range(0, 7)]);
            end
            5: add_u(16'($urandom_range(0, 16'h07FF)));
            6: begin
               v = 16'($urandom_range(16'h0800, 16'hFFFF));
               if (v >= 16'hD800 && v <= 16'hDFFF) v = v ^ 16'h4000;
               add_u(v);
            end
            7: begin
               add_u(16'($urandom_range(16'hD800, 16'hDBFF)));
               add_u(16'($urandom_range(16'hDC00, 16'hDFFF)));
            end
            8: add_u(16'($urandom_range(16'hD800, 16'hDFFF)));
            default: begin
               // High half followed by an escape that is not a \u.
               add_u(16'($urandom_range(16'hD800, 16'hDBFF)));
               text_q.push_back(CH_BSLASH);
               text_q.push_back(esc_letters[$urandom_range(0, 7)]);
            end
         endcase
      end
      text_q.push_back(CH_QUOTE);
   endtask

   task automatic damage_string(output logic with_eoi);
      int         pos;
      logic [7:0] c;
      with_eoi = 1'b0;
      case ($urandom_range(0, 4))
         0: begin
            pos = $urandom_range(0, text_q.size() - 1);
            while (text_q.size() > pos) void'(text_q.pop_back());
            with_eoi = 1'b1;
         end
         1: text_q[$urandom_range(1, text_q.size() - 1)] = 8'($urandom_range(0, 255));
         2: text_q[$urandom_range(1, text_q.size() - 1)] = 8'($urandom_range(0, 31));
         3: begin
            c = 8'($urandom_range(0, 255));
            if (c == CH_QUOTE) c = c ^ 8'h01;
            text_q[0] = c;
         end
         default: begin
            pos = $urandom_range(1, text_q.size() - 1);
            text_q.insert(pos, 8'($urandom_range(32, 126)));
            text_q.insert(pos, CH_BSLASH);
         end
      endcase
   endtask

   initial begin
      logic [jsu_pkg::CSR_WIDTH-1:0] limits[4];
      int                            idle_pcts[4];
      int                            stall_pcts[4];
      int                            start;
      logic                          eoi;

      limits     = '{24'hFF_FFFF, 24'd1, 24'd7, 24'($urandom_range(2, 40))};
      idle_pcts  = '{0, 63, 0, 6};
      stall_pcts = '{0, 0, 63, 6};

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed strings at the reset length limit.
      send_eoi();
      send_text("x");
      send_text("\"\"");
      send_text("\"ab~ \"");
      send_text("\"\\\"\\\\\\/\\b\\f\\n\\r\\t\"");
      // The result side holds off here long enough for the queue to fill.
      hold_req++;
      send_text("\"\\u0000\\u007F\\u0080\\u07ff\\u0800\\uFFFF\\uabcd\"");
      send_text("\"\\uD800\\uDC00\\uDBFF\\uDFFF\"");
      send_text("\"\\uD83Dx\"");
      send_text("\"\\uD83D\\n\"");
      send_text("\"\\uDBFF\"");
      send_text("\"\\uDC00\"");
      send_text("\"\\uD800\\u0041");
      send_text("\"\\uD800\\uDCz");
      send_text("\"\\u12G");
      send_text("\"\\q");
      send_text("\"a");
      send_beat(8'h01, 1'b0);
      send_text("\"");
      send_beat(8'h1F, 1'b0);
      send_text("\"");
      send_beat(8'h7F, 1'b0);
      send_beat(8'h80, 1'b0);
      send_beat(8'hFF, 1'b0);
      send_text("\"");
      // End of input in every phase of the parser.
      send_text("\"ab");
      send_eoi();
      send_text("\"\\");
      send_eoi();
      send_text("\"\\u12");
      send_eoi();
      send_text("\"\\uD800");
      send_eoi();
      send_text("\"\\uD800\\");
      send_eoi();
      send_text("\"\\uD800\\u");
      send_eoi();
      send_text("\"\\uD800\\uDC");
      send_eoi();

      // A sequence that does not fit is dropped; an exact fit still completes.
      write_limit(24'd3);
      send_text("\"ab\\u00e9c\"");
      send_text("\"abc\"");

      for (int p = 0; p < 4; p++) begin
         write_limit(limits[p]);
         send_idle_pct = idle_pcts[p];
         rsp_stall_pct = stall_pcts[p];
         start = beats_sent;
         while (beats_sent - start < PHASE_BEATS) begin
            build_string();
            eoi = 1'b0;
            if ($urandom_range(0, 99) < 30) damage_string(eoi);
            foreach (text_q[k]) send_beat(text_q[k], 1'b0);
            if (eoi) send_eoi();
         end
      end

      send_idle_pct = 0;
      rsp_stall_pct = 0;
      wait_drained();
      if (fail_count == 0) begin
         $display("tb_json_string_unescape_utf8_top OK");
      end else begin
         $display("tb_json_string_unescape_utf8_top NOT OK");
      end
      $finish;
   end

endmodule
